FILE: hdl/gbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants of the glyph bitmap expander.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    FONT_MONO = 2'd0,
    FONT_AA2  = 2'd1,
    FONT_AA4  = 2'd2
  } font_mode_e;

  typedef enum logic [1:0] {
    REG_FONT_MODE    = 2'd0,
    REG_GLYPH_HEIGHT = 2'd1,
    REG_DRAW_COLOR   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  font_mode;
    logic [7:0]  glyph_height;
    logic [31:0] draw_color;
  } cfg_t;

  typedef struct packed {
    logic               glyph_start;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [7:0]  glyph_width;
    logic        [5:0]  row_bytes;
    logic        [7:0]  glyph_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic        [31:0] pixel_color;
    logic               last_of_byte;
  } out_word_t;

  // one classified byte: x of slot 0, row y, raw bits, slots to draw
  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y;
    logic [7:0]  bits;
    logic [7:0]  mask;
    logic [1:0]  mode;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/gbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_front
// Accepts bitmap words, tracks glyph geometry and row/byte/column position,
// and turns each byte into a job with a mask of the pixel slots to draw.
// ----------------------------------------------------------------------------
module gbe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gbe_pkg::cfg_t   cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gbe_pkg::in_word_t in_word_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output gbe_pkg::job_t        job_o
);
  import gbe_pkg::*;

  logic [15:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [7:0]  width_q, width_d;
  logic [4:0]  bytes_q, bytes_d;
  logic [7:0]  row_q, row_d;
  logic [4:0]  bidx_q, bidx_d;
  logic [7:0]  col_q, col_d;

  logic [15:0] bx, by;
  logic [7:0]  w, row, col;
  logic [4:0]  bytes_e, bidx;
  logic [5:0]  rb_c, len, bidx_p1;
  logic        drop, eq_last, row_end, accept;
  logic [7:0]  used, rem, avail, col_adv;
  logic [3:0]  mono_cnt, cnt2, cnt4, cnt;
  logic [7:0]  nz1, nz2, nz4, nz, mask;
  logic [7:0]  b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_word_i.glyph_byte;

  always_comb begin
    if (in_word_i.row_bytes == 6'd0) begin
      rb_c = 6'd1;
    end else if (in_word_i.row_bytes > 6'd32) begin
      rb_c = 6'd32;
    end else begin
      rb_c = in_word_i.row_bytes;
    end
    // a new glyph restarts everything from its own geometry
    if (in_word_i.glyph_start) begin
      bx      = in_word_i.origin_x;
      by      = in_word_i.origin_y;
      w       = in_word_i.glyph_width;
      bytes_e = rb_c[4:0];
      row     = 8'd0;
      bidx    = 5'd0;
      col     = 8'd0;
    end else begin
      bx      = base_x_q;
      by      = base_y_q;
      w       = width_q;
      bytes_e = bytes_q;
      row     = row_q;
      bidx    = bidx_q;
      col     = col_q;
    end
  end

  assign len     = (bytes_e == 5'd0) ? 6'd32 : {1'b0, bytes_e};
  assign bidx_p1 = {1'b0, bidx} + 6'd1;
  assign eq_last = (bidx_p1 == len);
  assign row_end = (bidx_p1 >= len);
  assign drop    = (row >= cfg_i.glyph_height);
  assign used    = {bidx, 3'b000};
  assign rem     = w - used;
  assign avail   = (w > col) ? (w - col) : 8'd0;

  always_comb begin
    if (!eq_last) begin
      mono_cnt = 4'd8;
    end else if (w <= used) begin
      mono_cnt = 4'd0;
    end else if (rem > 8'd8) begin
      mono_cnt = 4'd8;
    end else begin
      mono_cnt = rem[3:0];
    end
    cnt2 = (avail >= 8'd4) ? 4'd4 : avail[3:0];
    cnt4 = (avail >= 8'd2) ? 4'd2 : avail[3:0];
  end

  always_comb begin
    nz1 = '0;
    nz2 = '0;
    nz4 = '0;
    for (int i = 0; i < 8; i++) begin
      nz1[i] = b[7-i];
    end
    for (int i = 0; i < 4; i++) begin
      nz2[i] = |b[7-2*i -: 2];
    end
    for (int i = 0; i < 2; i++) begin
      nz4[i] = |b[7-4*i -: 4];
    end
  end

  always_comb begin
    unique case (cfg_i.font_mode)
      FONT_MONO: begin
        cnt = mono_cnt; nz = nz1; col_adv = {4'd0, mono_cnt};
      end
      FONT_AA2: begin
        cnt = cnt2; nz = nz2; col_adv = {4'd0, cnt2};
      end
      FONT_AA4: begin
        cnt = cnt4; nz = nz4; col_adv = {4'd0, cnt4};
      end
      default: begin
        // unused mode: columns move as in mono, nothing drawn
        cnt = 4'd0; nz = '0; col_adv = 8'd8;
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      mask[i] = (4'(i) < cnt) && nz[i];
    end
  end

  assign job_o.x0   = bx + {8'd0, col};
  assign job_o.y    = by + {8'd0, row};
  assign job_o.bits = b;
  assign job_o.mask = mask;
  assign job_o.mode = cfg_i.font_mode;
  assign push_o     = accept && !drop && (mask != 8'd0);

  always_comb begin
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    width_d  = width_q;
    bytes_d  = bytes_q;
    row_d    = row_q;
    bidx_d   = bidx_q;
    col_d    = col_q;
    if (accept) begin
      base_x_d = bx;
      base_y_d = by;
      width_d  = w;
      bytes_d  = bytes_e;
      row_d    = row;
      bidx_d   = bidx;
      col_d    = col;
      if (!drop) begin
        if (row_end) begin
          row_d  = row + 8'd1;
          bidx_d = 5'd0;
          col_d  = 8'd0;
        end else begin
          bidx_d = bidx + 5'd1;
          col_d  = col + col_adv;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
      width_q  <= '0;
      bytes_q  <= 5'd1;
      row_q    <= '0;
      bidx_q   <= '0;
      col_q    <= '0;
    end else begin
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      width_q  <= width_d;
      bytes_q  <= bytes_d;
      row_q    <= row_d;
      bidx_q   <= bidx_d;
      col_q    <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_queue
// Short job FIFO between the classifier and the pixel emitter.
// ----------------------------------------------------------------------------
module gbe_queue #(
  parameter int DEPTH = gbe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gbe_pkg::job_t push_job_i,
  input  wire logic          pop_i,
  output gbe_pkg::job_t      head_o,
  output gbe_pkg::q_stat_t   stat_o
);
  import gbe_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_back
// Pixel emitter: walks the draw mask of one job, lowest slot first, one pixel
// word per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module gbe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gbe_pkg::cfg_t cfg_i,
  input  wire logic          q_valid_i,
  input  wire gbe_pkg::job_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gbe_pkg::out_word_t out_word_o
);
  import gbe_pkg::*;

  job_t      work_q, work_d;
  logic      work_v_q, work_v_d;
  out_word_t out_q, out_d;
  logic      out_v_q, out_v_d;

  logic       emit, last;
  logic [7:0] sel, rest;
  logic [2:0] k;
  logic [1:0] d2;
  logic [3:0] d4;
  logic [7:0] alpha;

  assign sel  = work_q.mask & (~work_q.mask + 8'd1);
  assign rest = work_q.mask & ~sel;

  always_comb begin
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work_q.mask[i]) begin
        k = 3'(i);
      end
    end
  end

  // slot k of 2bpp sits at bit 6-2k, of 4bpp at bit 4-4k
  assign d2 = work_q.bits[{~k[1:0], 1'b0} +: 2];
  assign d4 = work_q.bits[{~k[0], 2'b00} +: 4];

  always_comb begin
    unique case (work_q.mode)
      FONT_AA2: alpha = {4{~d2}};
      FONT_AA4: alpha = {2{~d4}};
      default:  alpha = 8'd0;
    endcase
  end

  assign emit  = work_v_q && (!out_v_q || out_ready_i);
  assign last  = emit && (rest == 8'd0);
  assign pop_o = q_valid_i && (!work_v_q || last);

  always_comb begin
    work_d   = work_q;
    work_v_d = work_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    if (pop_o) begin
      work_d   = head_i;
      work_v_d = 1'b1;
    end else if (last) begin
      work_v_d = 1'b0;
    end else if (emit) begin
      work_d.mask = rest;
    end
    if (emit) begin
      out_v_d                 = 1'b1;
      out_d.pixel_x           = work_q.x0 + {13'd0, k};
      out_d.pixel_y           = work_q.y;
      out_d.pixel_color       = cfg_i.draw_color | {alpha, 24'd0};
      out_d.last_of_byte      = (rest == 8'd0);
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      work_v_q <= work_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/glyph_bitmap_expander_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte's job passes the job queue, the work register and the output register.
// Throughput: one byte per cycle at the input while the job queue has room; the
// emitter gives one pixel per cycle unless the output stalls, 0 to 8 per byte.
// Bytes that draw nothing never reach the emitter; a 2-deep job queue decouples.
// Reset: counters and geometry cleared, bytes per row 1, height 16, mode mono.
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_unit
// Expands streamed 1/2/4 bpp glyph bitmap bytes into drawn pixel words.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander_unit #(
  parameter int QUEUE_DEPTH = gbe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gbe_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gbe_pkg::out_word_t      out_word_o
);
  import gbe_pkg::*;

  cfg_t    cfg_q;
  job_t    push_job, head;
  logic    push, pop;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_mode    <= FONT_MONO;
      cfg_q.glyph_height <= 8'd16;
      cfg_q.draw_color   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FONT_MODE:    cfg_q.font_mode    <= cfg_wdata_i[1:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_wdata_i[7:0];
        REG_DRAW_COLOR:   cfg_q.draw_color   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .job_o      (push_job)
  );

  gbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  gbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (!q_stat.empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  a_q_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_push_draws : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.mask != 8'd0))
    else $error("job queued with nothing to draw");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

FILE: sim/glyph_bitmap_expander_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_unit_tb
// Streams glyph bitmap bytes into the expander under all font modes. Expected
// pixel words come from a local model of the glyph counters and are compared
// in order against the output, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander_unit_tb;
  import gbe_pkg::*;

  localparam logic [1:0] FONT_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT   = 3000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         RANDOM_LIVE   = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  // shadow of the configuration and the glyph counters
  logic [1:0]  cfg_mode = FONT_MONO;
  logic [7:0]  cfg_height = 8'd16;
  logic [31:0] cfg_color = '0;
  logic [15:0] glyph_x = '0;
  logic [15:0] glyph_y = '0;
  logic [7:0]  glyph_w = '0;
  logic [4:0]  glyph_rb = 5'd1;
  logic [7:0]  row_at = '0;
  logic [4:0]  byte_at = '0;
  logic [7:0]  col_at = '0;

  out_word_t   pending_pixels[$];
  int          errors = 0;
  int          live_bytes = 0;
  int          dropped_bytes = 0;
  int          pixels_seen = 0;
  int          quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          idle_en = 1'b1;

  glyph_bitmap_expander_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t make_pixel(int unsigned col, logic [7:0] alpha);
    out_word_t p;
    p.pixel_x      = glyph_x + 16'(col);
    p.pixel_y      = glyph_y + {8'd0, row_at};
    p.pixel_color  = cfg_color | {alpha, 24'd0};
    p.last_of_byte = 1'b0;
    return p;
  endfunction

  // advance the glyph counters for one accepted byte, queue its pixels
  function automatic void expand_byte(in_word_t w);
    out_word_t   px[8];
    int unsigned n, cnt, used, len, col, i, d;
    logic [5:0]  rb;
    n = 0;
    if (w.glyph_start) begin
      rb = w.row_bytes;
      if (rb == 6'd0) rb = 6'd1;
      if (rb > 6'd32) rb = 6'd32;
      glyph_x  = w.origin_x;
      glyph_y  = w.origin_y;
      glyph_w  = w.glyph_width;
      glyph_rb = rb[4:0];
      row_at   = '0;
      byte_at  = '0;
      col_at   = '0;
    end
    if (row_at >= cfg_height) begin
      dropped_bytes++;
      return;
    end
    live_bytes++;
    len = (glyph_rb == 5'd0) ? 32 : glyph_rb;
    col = col_at;
    case (cfg_mode)
      FONT_MONO: begin
        cnt = 8;
        // last byte of a row carries only the leftover width
        if (byte_at + 1 == len) begin
          used = byte_at * 8;
          cnt  = (glyph_w > used) ? glyph_w - used : 0;
          if (cnt > 8) cnt = 8;
        end
        for (i = 0; i < cnt; i++) begin
          if (w.glyph_byte[7 - i]) begin
            px[n] = make_pixel(col, 8'd0);
            n++;
          end
          col++;
        end
      end
      FONT_AA2: begin
        for (i = 0; i < 4 && col < glyph_w; i++) begin
          d = (w.glyph_byte >> (6 - 2 * i)) & 2'h3;
          if (d != 0) begin
            px[n] = make_pixel(col, 8'((3 - d) * 85));
            n++;
          end
          col++;
        end
      end
      FONT_AA4: begin
        for (i = 0; i < 2 && col < glyph_w; i++) begin
          d = (w.glyph_byte >> (4 - 4 * i)) & 4'hf;
          if (d != 0) begin
            px[n] = make_pixel(col, 8'((15 - d) * 17));
            n++;
          end
          col++;
        end
      end
      default: col += 8;
    endcase
    if (byte_at + 1 >= len) begin
      byte_at = '0;
      col_at  = '0;
      row_at  = row_at + 8'd1;
    end else begin
      byte_at = byte_at + 5'd1;
      col_at  = 8'(col);
    end
    for (i = 0; i < n; i++) begin
      if (i == n - 1) px[i].last_of_byte = 1'b1;
      pending_pixels.push_back(px[i]);
    end
  endfunction

  task automatic send_byte(input logic start, input logic [15:0] ox, input logic [15:0] oy,
                           input logic [7:0] gw, input logic [5:0] rb, input logic [7:0] gb);
    in_word_t    w;
    int unsigned gap;
    w.glyph_start = start;
    w.origin_x    = ox;
    w.origin_y    = oy;
    w.glyph_width = gw;
    w.row_bytes   = rb;
    w.glyph_byte  = gb;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
    expand_byte(w);
  endtask

  // continuation byte: geometry fields are ignored, so fill them with noise
  task automatic send_data(input logic [7:0] gb);
    send_byte(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 6'($urandom), gb);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FONT_MODE:    cfg_mode   = data[1:0];
      REG_GLYPH_HEIGHT: cfg_height = data[7:0];
      default:          cfg_color  = data;
    endcase
  endtask

  // wait until every pixel is out and a byte drawing nothing has also cleared
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_mono_rows();
    write_reg(REG_FONT_MODE, FONT_MONO);
    write_reg(REG_GLYPH_HEIGHT, 32'd16);
    write_reg(REG_DRAW_COLOR, 32'hffff_ffff);
    // x wraps past the top of the range; second byte gives 5 of 13
    send_byte(1'b1, 16'h7fff, 16'h8000, 8'd13, 6'd2, 8'hff);
    send_data(8'hff);
    send_data(8'ha5);
    send_data(8'h00);
    // zero width, row bytes 0 taken as 1
    send_byte(1'b1, 16'h8000, 16'h7fff, 8'd0, 6'd0, 8'hff);
    // row bytes 63 taken as 32
    send_byte(1'b1, 16'h0000, 16'h0000, 8'd255, 6'd63, 8'h80);
    send_byte(1'b1, 16'h0040, 16'h0020, 8'd5, 6'd1, 8'h7f);
    settle_block();
  endtask

  task automatic test_antialiased();
    write_reg(REG_FONT_MODE, FONT_AA2);
    write_reg(REG_DRAW_COLOR, 32'h0012_3456);
    // width 3 stops mid byte
    send_byte(1'b1, 16'd10, 16'd20, 8'd3, 6'd1, 8'h1b);
    send_byte(1'b1, 16'd30, 16'd40, 8'd4, 6'd2, 8'hff);
    send_data(8'hff);
    settle_block();
    write_reg(REG_FONT_MODE, FONT_AA4);
    send_byte(1'b1, 16'hfff0, 16'hfff0, 8'd1, 6'd1, 8'hf0);
    send_byte(1'b1, 16'd5, 16'd6, 8'd2, 6'd1, 8'h0f);
    send_data(8'h18);
    settle_block();
  endtask

  task automatic test_height_limits();
    write_reg(REG_FONT_MODE, FONT_MONO);
    write_reg(REG_GLYPH_HEIGHT, 32'd1);
    write_reg(REG_DRAW_COLOR, 32'h0000_0000);
    send_byte(1'b1, 16'd100, 16'd200, 8'd8, 6'd1, 8'hff);
    send_data(8'hff);
    send_byte(1'b1, 16'd100, 16'd201, 8'd8, 6'd1, 8'h01);
    settle_block();
    write_reg(REG_GLYPH_HEIGHT, 32'd0);
    send_byte(1'b1, 16'd1, 16'd1, 8'd8, 6'd1, 8'hff);
    settle_block();
    // unused mode draws nothing but still walks the counters
    write_reg(REG_GLYPH_HEIGHT, 32'd255);
    write_reg(REG_FONT_MODE, FONT_UNUSED);
    send_byte(1'b1, 16'd50, 16'd60, 8'd8, 6'd2, 8'hff);
    send_data(8'hff);
    send_data(8'hff);
    settle_block();
    write_reg(REG_FONT_MODE, FONT_MONO);
    send_data(8'h80);
    send_data(8'h80);
    settle_block();
  endtask

  task automatic test_output_hold();
    int k;
    write_reg(REG_FONT_MODE, FONT_MONO);
    write_reg(REG_GLYPH_HEIGHT, 32'd16);
    write_reg(REG_DRAW_COLOR, $urandom);
    idle_en   = 1'b0;
    hold_left = HOLD_CYCLES;
    send_byte(1'b1, 16'($urandom), 16'($urandom), 8'd16, 6'd2, 8'hff);
    for (k = 0; k < 11; k++) send_data(8'($urandom) | 8'h81);
    settle_block();
    idle_en = 1'b1;
  endtask

  task automatic random_glyph();
    int unsigned rb, eff, rows, gw, r, k;
    rb   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 3);
    eff  = (rb == 0) ? 1 : (rb > 32) ? 32 : rb;
    rows = (eff > 4) ? 1 : $urandom_range(1, 4);
    case (cfg_mode)
      FONT_MONO: gw = $urandom_range(8 * eff - 8, 8 * eff);
      FONT_AA2:  gw = $urandom_range(4 * eff - 4, 4 * eff);
      FONT_AA4:  gw = $urandom_range(2 * eff - 2, 2 * eff);
      default:   gw = $urandom_range(0, 255);
    endcase
    if (gw > 255 || $urandom_range(0, 7) == 0) gw = $urandom_range(0, 255);
    for (r = 0; r < rows; r++) begin
      for (k = 0; k < eff; k++) begin
        if ($urandom_range(0, 11) == 0)
          send_byte(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    6'($urandom), 8'($urandom));
        else if (r == 0 && k == 0)
          send_byte(1'b1, 16'($urandom), 16'($urandom), 8'(gw), 6'(rb), 8'($urandom));
        else
          send_data(8'($urandom));
      end
    end
  endtask

  task automatic test_random_glyphs();
    int live_start, phase_live, phase_bytes, phases;
    live_start = live_bytes;
    phases     = 0;
    while (live_bytes - live_start < RANDOM_LIVE || phases < 5) begin
      settle_block();
      idle_en = ($urandom_range(0, 3) != 0);
      write_reg(REG_FONT_MODE,
                ($urandom_range(0, 7) == 0) ? FONT_UNUSED : 2'($urandom_range(0, 2)));
      case ($urandom_range(0, 4))
        0:       write_reg(REG_GLYPH_HEIGHT, 32'd1);
        1:       write_reg(REG_GLYPH_HEIGHT, 32'd255);
        default: write_reg(REG_GLYPH_HEIGHT, $urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_DRAW_COLOR, 32'h0000_0000);
        1:       write_reg(REG_DRAW_COLOR, 32'hffff_ffff);
        default: write_reg(REG_DRAW_COLOR, $urandom);
      endcase
      phase_live  = live_bytes;
      phase_bytes = live_bytes + dropped_bytes;
      while (live_bytes - phase_live < 10 && live_bytes + dropped_bytes - phase_bytes < 16)
        random_glyph();
      phases++;
    end
    settle_block();
  endtask

  // receiver: random stall per word, plus a long hold on request
  initial begin : pixel_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) stall_left = idle_en ? $urandom_range(0, 10) : 0;
    end
  end

  always @(posedge clk) begin : compare_pixel
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d color=%h", out_word.pixel_x,
               out_word.pixel_y, out_word.pixel_color);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_word.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_word.pixel_x);
          errors++;
        end
        if (out_word.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_word.pixel_y);
          errors++;
        end
        if (out_word.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, got %h", want.pixel_color, out_word.pixel_color);
          errors++;
        end
        if (out_word.last_of_byte !== want.last_of_byte) begin
          $error("last_of_byte: expected %0d, got %0d", want.last_of_byte,
                 out_word.last_of_byte);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_mono_rows();
    test_antialiased();
    test_height_limits();
    test_output_hold();
    test_random_glyphs();
    $display("Ran %0d bitmap bytes (%0d dropped below the glyph), checked %0d pixel words.",
             live_bytes + dropped_bytes, dropped_bytes, pixels_seen);
    $display("Modes mono, 2bpp, 4bpp and unused; heights 0, 1 and 255; long output hold.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
